@@ design/cgrf_pkg.sv @@
// Shared types and constants for the character grid rotate/flip unit.
// Holds request/response payloads, opcodes and the internal command format.
// No dependencies.
`timescale 1ns / 1ps

package cgrf_pkg;

  // Request opcodes
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_ROTATE = 3'd2;
  localparam logic [2:0] OP_MIRROR = 3'd3;
  localparam logic [2:0] OP_HALF   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // Command kinds handed from the front to the back
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Widest physical address: a 256 x 256 grid
  localparam int ADDR_MAX_W = 16;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SPACE_GLYPH = 8'h20;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] glyph;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_glyph;
    logic       status;
  } rsp_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [ADDR_MAX_W-1:0] addr;
    logic [7:0]            glyph;
    logic                  bad;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

@@ design/cgrf_front.sv @@
// Front end: accepts requests, checks coordinates, tracks orientation and
// maps logical coordinates to physical store addresses. Uses cgrf_pkg.
`timescale 1ns / 1ps

module cgrf_front import cgrf_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  req_item_t    req_data,
  input  logic         queue_full,
  input  back_status_t back_status,
  output logic         push,
  output cmd_t         cmd
);

  localparam int CW    = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CW-1:0] LAST_COORD = CW'(GRID_SIZE - 1);

  logic [1:0]    quarter_turns, quarter_turns_next;
  logic          mirrored, mirrored_next;
  logic          accept;
  logic          is_access, bad;
  logic [CW-1:0] r_in, c_in, r_rot, c_rot, c_phys;
  logic [AW-1:0] phys_addr;

  // Hold off requests while the store is swept after reset, or queue is full
  assign req_stall = queue_full | back_status.init_busy;
  assign accept    = req_valid & ~req_stall;
  assign push      = accept;

  // Range check on the logical coordinates
  always_comb begin
    is_access = req_data.opcode inside {OP_WRITE, OP_READ};
    bad = is_access &&
          ((9'(req_data.row) >= 9'(GRID_SIZE)) || (9'(req_data.column) >= 9'(GRID_SIZE)));
  end

  // Map logical to physical: undo the turns, then the mirror
  always_comb begin
    r_in = req_data.row[CW-1:0];
    c_in = req_data.column[CW-1:0];
    case (quarter_turns)
      2'd0: begin
        r_rot = r_in;
        c_rot = c_in;
      end
      2'd1: begin
        r_rot = LAST_COORD - c_in;
        c_rot = r_in;
      end
      2'd2: begin
        r_rot = LAST_COORD - r_in;
        c_rot = LAST_COORD - c_in;
      end
      default: begin
        r_rot = c_in;
        c_rot = LAST_COORD - r_in;
      end
    endcase
    c_phys    = mirrored ? (LAST_COORD - c_rot) : c_rot;
    phys_addr = AW'(AW'(r_rot) * AW'(GRID_SIZE)) + AW'(c_phys);
  end

  // Classify into a command for the back end
  always_comb begin
    cmd.addr  = ADDR_MAX_W'(phys_addr);
    cmd.glyph = req_data.glyph;
    cmd.bad   = bad;
    case (req_data.opcode)
      OP_WRITE: cmd.kind = bad ? CMD_NONE : CMD_WRITE;
      OP_READ:  cmd.kind = bad ? CMD_NONE : CMD_READ;
      OP_CLEAR: cmd.kind = CMD_CLEAR;
      default:  cmd.kind = CMD_NONE;
    endcase
  end

  // Advance the orientation
  always_comb begin
    quarter_turns_next = quarter_turns;
    mirrored_next      = mirrored;
    if (accept) begin
      case (req_data.opcode)
        OP_ROTATE: quarter_turns_next = quarter_turns + 2'd1;
        OP_MIRROR: begin
          quarter_turns_next = 2'd0 - quarter_turns;
          mirrored_next      = ~mirrored;
        end
        OP_HALF:   quarter_turns_next = quarter_turns + 2'd2;
        OP_CLEAR: begin
          quarter_turns_next = 2'd0;
          mirrored_next      = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_turns <= 2'd0;
      mirrored      <= 1'b0;
    end else begin
      quarter_turns <= quarter_turns_next;
      mirrored      <= mirrored_next;
    end
  end

endmodule

@@ design/cgrf_queue.sv @@
// Short command queue between front and back of the grid unit.
// Holds cgrf_pkg::cmd_t entries in flip-flops. Uses cgrf_pkg.
`timescale 1ns / 1ps

module cgrf_queue import cgrf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign full  = (count == NW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/cgrf_back.sv @@
// Back end: owns the frame store, executes queued commands, runs clearing
// sweeps and drives the response register. Uses cgrf_pkg.
`timescale 1ns / 1ps

module cgrf_back import cgrf_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         head,
  input  logic         empty,
  output logic         pop,
  output back_status_t back_status,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output rsp_item_t    rsp_data
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [7:0]    frame_store [DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] cmd_addr;
  logic          sweeping, init_busy;
  logic          s1_valid, s1_read, s1_status, s1_adv;

  assign back_status.init_busy = init_busy;
  assign cmd_addr = head.addr[AW-1:0];

  // Move a stage-one result out when the response slot frees up
  assign s1_adv = s1_valid & (~rsp_valid | ~rsp_stall);
  assign pop    = ~empty & ~sweeping & (~s1_valid | s1_adv);

  // Frame store: one write port (sweep or command), one registered read
  always_ff @(posedge clk) begin
    if (sweeping) begin
      frame_store[sweep_addr] <= SPACE_GLYPH;
    end else if (pop && head.kind == CMD_WRITE) begin
      frame_store[cmd_addr] <= head.glyph;
    end
    if (pop && head.kind == CMD_READ) begin
      rdata <= frame_store[cmd_addr];
    end
  end

  // Clearing sweep, one entry a cycle; starts at reset and on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      init_busy  <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      if (sweep_addr == LAST_ADDR) begin
        sweeping  <= 1'b0;
        init_busy <= 1'b0;
      end else begin
        sweep_addr <= sweep_addr + 1'b1;
      end
    end else if (pop && head.kind == CMD_CLEAR) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end
  end

  // Stage one: command issued to the store, waiting for its read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_read   <= (head.kind == CMD_READ);
      s1_status <= head.bad;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp_data.read_glyph <= s1_read ? rdata : 8'h00;
      rsp_data.status     <= s1_status;
    end
  end

  // A sweep ends only after covering the last entry
  a_sweep_ends_at_last: assert property (@(posedge clk) disable iff (rst)
    $fell(sweeping) |-> $past(sweep_addr) == LAST_ADDR)
    else $error("sweep ended early");

  // No command is issued to the store during a sweep
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !pop)
    else $error("command issued during sweep");

  // A blocked stage-one result is kept
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && rsp_stall |=> s1_valid && $stable(s1_status))
    else $error("stage one result lost");

  // The initial sweep never restarts once finished
  a_init_once: assert property (@(posedge clk) disable iff (rst)
    !init_busy |=> !init_busy)
    else $error("initial sweep restarted");

endmodule

@@ design/character_grid_rotate_flip_unit.sv @@
// Character grid with rotate, mirror, clear and single-cell read and write.
// A response is registered after its request passes the command queue and stage one.
// Throughput: one request per cycle while req_stall is low; a clear sweeps all
// GRID_SIZE^2 entries through the single write port, while later requests wait in queue.
// Reset: a clearing pass over all GRID_SIZE^2 entries fills the store with spaces,
// with req_stall high throughout. Uses cgrf_pkg and the cgrf_* modules.
`timescale 1ns / 1ps

module character_grid_rotate_flip_unit import cgrf_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp_data
);

  cmd_t         push_cmd, head;
  logic         push, pop, full, empty;
  back_status_t back_status;

  cgrf_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .queue_full  (full),
    .back_status (back_status),
    .push        (push),
    .cmd         (push_cmd)
  );

  cgrf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  cgrf_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .back_status (back_status),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data)
  );

endmodule
